// File: rtl/assert_macros.svh
// assertion macros, included by gab_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/gab_pkg.sv
// types and constants of the glyph alpha blit
`default_nettype none

package gab_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOUR = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WEIGHT,
    S_BLEND
  } gab_state_e;

  typedef struct packed {
    logic load_in;
    logic load_w;
    logic load_out;
  } gab_cmd_t;

endpackage

`default_nettype wire

// File: rtl/gab_ctrl.sv
// controller: sequencing of one transaction and the output valid flag
`default_nettype none

module gab_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output gab_pkg::gab_cmd_t cmd_o
);
  import gab_pkg::*;

  `include "assert_macros.svh"

  gab_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_w   = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_WEIGHT;
        end
      end
      S_WEIGHT: begin
        cmd_o.load_w = 1'b1;
        state_d      = S_BLEND;
      end
      S_BLEND: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_accept_starts_work, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> (state_q == S_WEIGHT && in_stall_o))
  `ASSERT_CLK(a_taken_result_drops, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && !cmd_o.load_out) |=> !out_valid_o)
  `ASSERT_CLK(a_blend_waits_on_stall, clk_i, rst_ni,
    (state_q == S_BLEND && out_valid_o && out_stall_i) |=> (state_q == S_BLEND))
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    cmd_o.load_out && out_valid_q && out_stall_i)

endmodule

`default_nettype wire

// File: rtl/gab_dp.sv
// datapath: config registers, glyph counters, clipping, weight, blend
`default_nettype none

module gab_dp #(
  parameter int unsigned MAX_GLYPH_SIDE  = 64,
  parameter int unsigned MAX_BITMAP_SIDE = 4096
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  gab_pkg::gab_cmd_t                cmd_i,
  input  wire                              cfg_we_i,
  input  wire  [gab_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [gab_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire  [7:0]                       coverage_i,
  input  wire  [31:0]                      dest_pixel_i,
  output logic [31:0]                      blended_pixel_o,
  output logic [23:0]                      pixel_index_o,
  output logic                             write_enable_o,
  output logic                             last_pixel_o
);
  import gab_pkg::*;

  localparam int unsigned CNT_W = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
  localparam logic [8:0]  GMAX  = 9'(MAX_GLYPH_SIDE);
  localparam logic [14:0] BMAX  = 15'(MAX_BITMAP_SIDE);

  // configuration
  logic [6:0]  glyph_cols_q, glyph_rows_q;
  logic [12:0] origin_x_q, origin_y_q, bitmap_cols_q, bitmap_rows_q;
  logic [31:0] colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_cols_q  <= 7'd8;
      glyph_rows_q  <= 7'd8;
      origin_x_q    <= 13'd0;
      origin_y_q    <= 13'd0;
      bitmap_cols_q <= 13'd640;
      bitmap_rows_q <= 13'd480;
      colour_q      <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GLYPH_COLS:  glyph_cols_q  <= cfg_data_i[6:0];
        CFG_GLYPH_ROWS:  glyph_rows_q  <= cfg_data_i[6:0];
        CFG_ORIGIN_X:    origin_x_q    <= cfg_data_i[12:0];
        CFG_ORIGIN_Y:    origin_y_q    <= cfg_data_i[12:0];
        CFG_BITMAP_COLS: bitmap_cols_q <= cfg_data_i[12:0];
        CFG_BITMAP_ROWS: bitmap_rows_q <= cfg_data_i[12:0];
        CFG_TEXT_COLOUR: colour_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [8:0]  gc, gr;
  logic [12:0] bc, br;

  always_comb begin
    if (glyph_cols_q == 7'd0) begin
      gc = 9'd1;
    end else if ({2'b00, glyph_cols_q} > GMAX) begin
      gc = GMAX;
    end else begin
      gc = {2'b00, glyph_cols_q};
    end
    if (glyph_rows_q == 7'd0) begin
      gr = 9'd1;
    end else if ({2'b00, glyph_rows_q} > GMAX) begin
      gr = GMAX;
    end else begin
      gr = {2'b00, glyph_rows_q};
    end
    bc = ({2'b00, bitmap_cols_q} > BMAX) ? BMAX[12:0] : bitmap_cols_q;
    br = ({2'b00, bitmap_rows_q} > BMAX) ? BMAX[12:0] : bitmap_rows_q;
  end

  // glyph counters and clipping
  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic signed [13:0] x_s, y_s;
  logic              row_end, last, in_bounds;

  always_comb begin
    x_s       = $signed({origin_x_q[12], origin_x_q}) + $signed({1'b0, 13'(col_q)});
    y_s       = $signed({origin_y_q[12], origin_y_q}) + $signed({1'b0, 13'(row_q)});
    in_bounds = !x_s[13] && !y_s[13] && (x_s[12:0] < bc) && (y_s[12:0] < br);
    row_end   = (9'(col_q) + 9'd1) >= gc;
    last      = row_end && ((9'(row_q) + 9'd1) >= gr);
    col_d     = col_q;
    row_d     = row_q;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + CNT_W'(1);
    end else begin
      col_d = col_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_in) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input capture
  logic [7:0]  cov_q;
  logic [31:0] dst_q;
  logic [12:0] x_q, y_q;
  logic        in_bounds_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cov_q       <= coverage_i;
      dst_q       <= dest_pixel_i;
      x_q         <= x_s[12:0];
      y_q         <= y_s[12:0];
      in_bounds_q <= in_bounds;
      last_q      <= last;
    end
  end

  // weight and linear index
  logic [15:0] cov_alpha;
  logic [25:0] row_base;
  logic [25:0] idx_sum;
  logic [8:0]  w_q;
  logic [23:0] idx_q;

  assign cov_alpha = 16'(cov_q) * 16'(colour_q[31:24]);
  assign row_base  = 26'(y_q) * 26'(bc);
  assign idx_sum   = row_base + 26'(x_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_w) begin
      w_q   <= 9'(cov_alpha[15:8]) + 9'd1;
      idx_q <= idx_sum[23:0];
    end
  end

  // per-channel blend
  logic [23:0] mix;

  always_comb begin
    logic [7:0]  d, s, diff;
    logic [16:0] prod;
    mix = '0;
    for (int i = 0; i < 3; i++) begin
      d = dst_q[8*i +: 8];
      s = colour_q[8*i +: 8];
      if (s >= d) begin
        diff = s - d;
        prod = 17'(diff) * 17'(w_q);
        mix[8*i +: 8] = d + prod[15:8];
      end else begin
        diff = d - s;
        prod = (17'(diff) * 17'(w_q)) + 17'd255;
        mix[8*i +: 8] = d - prod[15:8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      blended_pixel_o <= in_bounds_q ? {dst_q[31:24], mix} : dst_q;
      pixel_index_o   <= in_bounds_q ? idx_q : 24'd0;
      write_enable_o  <= in_bounds_q;
      last_pixel_o    <= last_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/clipped_glyph_alpha_blit.sv
// top level of the clipped glyph alpha blit
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i/in_stall_o   coverage_i, dest_pixel_i
//  out      source     out_valid_o/out_stall_i blended_pixel_o, pixel_index_o,
//                                              write_enable_o, last_pixel_o
//  cfg      sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// one transaction runs through capture, weight and index multiply, then blend
// the two multiplier stages are shared in turn by one item at a time
// a finished result sits in the output register while the next item is taken
// a stalled output holds the blend stage until the register is free
// reset loads the config defaults and clears the counters and the output valid flag
`default_nettype none

module clipped_glyph_alpha_blit #(
  parameter int unsigned MAX_GLYPH_SIDE  = 64,
  parameter int unsigned MAX_BITMAP_SIDE = 4096
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [7:0]                     coverage_i,
  input  wire  [31:0]                    dest_pixel_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [31:0]                    blended_pixel_o,
  output logic [23:0]                    pixel_index_o,
  output logic                           write_enable_o,
  output logic                           last_pixel_o,
  input  wire                            cfg_we_i,
  input  wire  [gab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [gab_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gab_pkg::*;

  gab_cmd_t cmd;

  gab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  gab_dp #(
    .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE),
    .MAX_BITMAP_SIDE(MAX_BITMAP_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .coverage_i     (coverage_i),
    .dest_pixel_i   (dest_pixel_i),
    .blended_pixel_o(blended_pixel_o),
    .pixel_index_o  (pixel_index_o),
    .write_enable_o (write_enable_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

`default_nettype wire
